// ----- hw/rtl/sdspi_pkg.sv -----
`timescale 1ns / 1ps
package sdspi_pkg;

  localparam int unsigned BlockBytes = 512;
  localparam int unsigned WakeBytes  = 80;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_BYTE  = 2'd3
  } op_e;

  localparam logic [4:0] ST_IDLE     = 5'd0;
  localparam logic [4:0] ST_WAKE     = 5'd1;
  localparam logic [4:0] ST_CMD0     = 5'd2;
  localparam logic [4:0] ST_CMD8     = 5'd3;
  localparam logic [4:0] ST_CMD1     = 5'd4;
  localparam logic [4:0] ST_CMD58A   = 5'd5;
  localparam logic [4:0] ST_CMD59ON  = 5'd6;
  localparam logic [4:0] ST_CMD55    = 5'd7;
  localparam logic [4:0] ST_ACMD41   = 5'd8;
  localparam logic [4:0] ST_CMD59OFF = 5'd9;
  localparam logic [4:0] ST_CMD16    = 5'd10;
  localparam logic [4:0] ST_CMD58B   = 5'd11;
  localparam logic [4:0] ST_RD_CMD   = 5'd12;
  localparam logic [4:0] ST_WR_CMD   = 5'd13;
  localparam logic [4:0] ST_RD_TOKEN = 5'd14;
  localparam logic [4:0] ST_RD_DATA  = 5'd15;
  localparam logic [4:0] ST_RD_CRC   = 5'd16;
  localparam logic [4:0] ST_WR_DATA  = 5'd17;
  localparam logic [4:0] ST_WR_CRC   = 5'd18;
  localparam logic [4:0] ST_WR_BUSY  = 5'd19;

  localparam logic [1:0] PH_READY = 2'd0;
  localparam logic [1:0] PH_CMD   = 2'd1;
  localparam logic [1:0] PH_R1    = 2'd2;
  localparam logic [1:0] PH_R32   = 2'd3;

  localparam logic [3:0] STAT_OK          = 4'd0;
  localparam logic [3:0] STAT_NO_CARD     = 4'd1;
  localparam logic [3:0] STAT_NOT_READY   = 4'd2;
  localparam logic [3:0] STAT_UNUSABLE    = 4'd3;
  localparam logic [3:0] STAT_ECHO        = 4'd4;
  localparam logic [3:0] STAT_VOLTAGE     = 4'd5;
  localparam logic [3:0] STAT_R1_ERROR    = 4'd6;
  localparam logic [3:0] STAT_NO_TOKEN    = 4'd7;
  localparam logic [3:0] STAT_ACCEPTED    = 4'd8;
  localparam logic [3:0] STAT_CRC_REJECT  = 4'd9;
  localparam logic [3:0] STAT_WR_REJECT   = 4'd10;
  localparam logic [3:0] STAT_WR_ERROR    = 4'd11;

  localparam logic [0:0] REG_POLL_LIMIT = 1'd0;
  localparam logic [0:0] REG_VOLT_MASK  = 1'd1;

  typedef struct packed {
    logic [4:0]  step;
    logic [1:0]  phase;
    logic [9:0]  byte_count;
    logic [15:0] poll_count;
    logic [15:0] retry_count;
    logic [31:0] response_shift;
    logic [1:0]  card_capacity;
    logic [31:0] latched_address;
    logic [7:0]  last_response;
    logic        cs_low;
    logic        fast_clk;
  } seq_state_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] block_address;
    logic [7:0]  rx_byte;
    logic [7:0]  write_byte;
  } req_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       chip_select_low;
    logic       fast_clock;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       need_write_byte;
    logic       done_res;
    logic [3:0] status;
    logic [7:0] r1_value;
  } res_t;

  typedef struct packed {
    logic [15:0] poll_limit;
    logic [31:0] ocr_mask;
  } cfg_t;

endpackage

// ----- hw/rtl/sd_spi_mode_host_sequencer.sv -----
`timescale 1ns / 1ps
// SD card SPI-mode host sequencer. Each accepted request (start init, start read, start write,
// or one exchanged byte) yields exactly one result giving the next byte to send, the pin
// levels, any block data byte and the end status of an operation. Requests are taken one per
// cycle while the skid register is empty; the state update is one registered step, and the result
// lands in the output register, or in the skid register while the output is stalled.
module sd_spi_mode_host_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [31:0] block_address_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [7:0]  write_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        tx_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        chip_select_low_o,
  output logic        fast_clock_o,
  output logic        read_valid_o,
  output logic [7:0]  read_byte_o,
  output logic        need_write_byte_o,
  output logic        done_res_o,
  output logic [3:0]  status_o,
  output logic [7:0]  r1_value_o
);

  sdspi_pkg::cfg_t       cfg;
  sdspi_pkg::seq_state_t state_q;
  sdspi_pkg::seq_state_t state_d;
  sdspi_pkg::req_t       req;
  sdspi_pkg::res_t       res;
  sdspi_pkg::res_t       out_q;
  sdspi_pkg::res_t       skid_q;
  logic                  out_valid_q;
  logic                  skid_valid_q;
  logic                  in_fire;

  sdspi_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign req.op            = op_i;
  assign req.block_address = block_address_i;
  assign req.rx_byte       = rx_byte_i;
  assign req.write_byte    = write_byte_i;

  sdspi_step u_step (
    .cur_i (state_q),
    .req_i (req),
    .cfg_i (cfg),
    .nxt_o (state_d),
    .res_o (res)
  );

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || out_ready_i) begin
        out_valid_q  <= in_fire || skid_valid_q;
        skid_valid_q <= 1'b0;
      end else if (in_fire) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (in_fire) begin
      skid_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign tx_valid_o        = out_q.tx_valid;
  assign tx_byte_o         = out_q.tx_byte;
  assign chip_select_low_o = out_q.chip_select_low;
  assign fast_clock_o      = out_q.fast_clock;
  assign read_valid_o      = out_q.read_valid;
  assign read_byte_o       = out_q.read_byte;
  assign need_write_byte_o = out_q.need_write_byte;
  assign done_res_o        = out_q.done_res;
  assign status_o          = out_q.status;
  assign r1_value_o        = out_q.r1_value;

`ifndef SYNTH
  a_skid_only_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry without a pending result");
  a_no_accept_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !in_ready_o)
    else $error("request accepted with both stages full");
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted request produced no result");
  a_idle_state_no_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && state_d.step == sdspi_pkg::ST_IDLE) |-> !res.tx_valid)
    else $error("exchange requested while idle");
`endif

endmodule

// ----- hw/rtl/sdspi_regs.sv -----
`timescale 1ns / 1ps
module sdspi_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output sdspi_pkg::cfg_t    cfg_o
);

  logic [15:0] poll_limit_q;
  logic [31:0] volt_mask_q;
  logic        wr_en;
  logic [0:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_limit_q <= 16'd1000;
      volt_mask_q  <= 32'h00FF8000;
    end else if (wr_en && paddr[1:0] == 2'b00) begin
      if (reg_idx == sdspi_pkg::REG_POLL_LIMIT) begin
        poll_limit_q <= pwdata[15:0];
      end else begin
        volt_mask_q <= pwdata;
      end
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (reg_idx == sdspi_pkg::REG_POLL_LIMIT) begin
      prdata = {16'd0, poll_limit_q};
    end else begin
      prdata = volt_mask_q;
    end
  end

  assign cfg_o.poll_limit = poll_limit_q;
  assign cfg_o.ocr_mask   = volt_mask_q;

endmodule

// ----- hw/rtl/sdspi_step.sv -----
`timescale 1ns / 1ps
module sdspi_step (
  input  sdspi_pkg::seq_state_t cur_i,
  input  sdspi_pkg::req_t       req_i,
  input  sdspi_pkg::cfg_t       cfg_i,
  output sdspi_pkg::seq_state_t nxt_o,
  output sdspi_pkg::res_t       res_o
);

  sdspi_pkg::seq_state_t n;
  sdspi_pkg::res_t       r;
  logic [15:0] lim;
  logic [15:0] poll_inc;
  logic [15:0] retry_inc;
  logic        poll_over;
  logic        retry_over;
  logic [9:0]  bc_inc;
  logic [7:0]  rx;
  logic [2:0]  wcode;
  logic [7:0]  cidx;
  logic [7:0]  ccrc;
  logic [31:0] carg;

  always_comb begin
    lim        = (cfg_i.poll_limit == 16'd0) ? 16'd1 : cfg_i.poll_limit;
    poll_inc   = cur_i.poll_count + 16'd1;
    retry_inc  = cur_i.retry_count + 16'd1;
    poll_over  = poll_inc >= lim;
    retry_over = retry_inc >= lim;
    bc_inc     = cur_i.byte_count + 10'd1;
    rx         = req_i.rx_byte;
    wcode      = cur_i.last_response[3:1];
    n = cur_i;
    r = '0;

    case (req_i.op)
      sdspi_pkg::OP_INIT: begin
        n.cs_low     = 1'b0;
        n.fast_clk   = 1'b0;
        n.step       = sdspi_pkg::ST_WAKE;
        n.byte_count = '0;
      end
      sdspi_pkg::OP_READ, sdspi_pkg::OP_WRITE: begin
        n.cs_low = 1'b1;
        n.latched_address = (cur_i.card_capacity == 2'd2) ?
                            {req_i.block_address[22:0], 9'd0} : req_i.block_address;
        n.step = (req_i.op == sdspi_pkg::OP_READ) ? sdspi_pkg::ST_RD_CMD :
                                                    sdspi_pkg::ST_WR_CMD;
        n.phase      = sdspi_pkg::PH_READY;
        n.byte_count = '0;
        n.poll_count = '0;
      end
      default: begin
        if (cur_i.step == sdspi_pkg::ST_WAKE) begin
          n.byte_count = bc_inc;
          if (bc_inc >= 10'(sdspi_pkg::WakeBytes)) begin
            n.cs_low = 1'b1;
            n.retry_count = '0;
            n.step = sdspi_pkg::ST_CMD0;
            n.phase = sdspi_pkg::PH_CMD;
            n.byte_count = '0;
            n.poll_count = '0;
          end
        end else if (cur_i.step inside {[sdspi_pkg::ST_CMD0:sdspi_pkg::ST_WR_CMD]}) begin
          case (cur_i.phase)
            sdspi_pkg::PH_READY: begin
              if (rx == 8'hFF) begin
                n.phase = sdspi_pkg::PH_CMD;
                n.byte_count = '0;
              end else begin
                n.poll_count = poll_inc;
                if (poll_over) begin
                  n.step = sdspi_pkg::ST_IDLE;
                  r.done_res = 1'b1;
                  r.status = sdspi_pkg::STAT_NOT_READY;
                end
              end
            end
            sdspi_pkg::PH_CMD: begin
              n.byte_count = bc_inc;
              if (bc_inc >= 10'd6) begin
                n.phase = sdspi_pkg::PH_R1;
                n.byte_count = '0;
              end
            end
            sdspi_pkg::PH_R1: begin
              n.byte_count = bc_inc;
              if (bc_inc >= 10'd2) begin
                n.last_response = rx;
                if ((cur_i.step == sdspi_pkg::ST_CMD8 && rx == 8'h01) ||
                    (cur_i.step == sdspi_pkg::ST_CMD58A && rx == 8'h01) ||
                    (cur_i.step == sdspi_pkg::ST_CMD58B && rx == 8'h00)) begin
                  n.phase = sdspi_pkg::PH_R32;
                  n.byte_count = '0;
                  n.response_shift = '0;
                end else begin
                  n.phase = sdspi_pkg::PH_READY;
                  n.byte_count = '0;
                  n.poll_count = '0;
                  case (cur_i.step)
                    sdspi_pkg::ST_CMD0: begin
                      if (rx == 8'h01) begin
                        n.step = sdspi_pkg::ST_CMD8;
                      end else begin
                        n.retry_count = retry_inc;
                        if (retry_over) begin
                          n = cur_i;
                          n.retry_count = retry_inc;
                          n.byte_count = bc_inc;
                          n.last_response = rx;
                          n.step = sdspi_pkg::ST_IDLE;
                          r.done_res = 1'b1;
                          r.status = sdspi_pkg::STAT_NO_CARD;
                        end else begin
                          n.phase = sdspi_pkg::PH_CMD;
                        end
                      end
                    end
                    sdspi_pkg::ST_CMD8: begin
                      n.retry_count = '0;
                      n.step = sdspi_pkg::ST_CMD1;
                    end
                    sdspi_pkg::ST_CMD1, sdspi_pkg::ST_ACMD41: begin
                      if (rx == 8'h00) begin
                        n.step = sdspi_pkg::ST_CMD59OFF;
                      end else begin
                        n.retry_count = retry_inc;
                        if (retry_over) begin
                          n = cur_i;
                          n.retry_count = retry_inc;
                          n.byte_count = bc_inc;
                          n.last_response = rx;
                          n.step = sdspi_pkg::ST_IDLE;
                          r.done_res = 1'b1;
                          r.status = sdspi_pkg::STAT_UNUSABLE;
                        end else if (cur_i.step == sdspi_pkg::ST_ACMD41) begin
                          n.step = sdspi_pkg::ST_CMD55;
                        end
                      end
                    end
                    sdspi_pkg::ST_CMD59ON: begin
                      if (rx != 8'h01) begin
                        n = cur_i;
                        n.byte_count = bc_inc;
                        n.last_response = rx;
                        n.step = sdspi_pkg::ST_IDLE;
                        r.done_res = 1'b1;
                        r.status = sdspi_pkg::STAT_R1_ERROR;
                        r.r1_value = rx;
                      end else begin
                        n.retry_count = '0;
                        n.step = sdspi_pkg::ST_CMD55;
                      end
                    end
                    sdspi_pkg::ST_CMD55: begin
                      n.step = sdspi_pkg::ST_ACMD41;
                    end
                    sdspi_pkg::ST_CMD59OFF, sdspi_pkg::ST_CMD16,
                    sdspi_pkg::ST_RD_CMD, sdspi_pkg::ST_WR_CMD: begin
                      if (rx != 8'h00) begin
                        n = cur_i;
                        n.byte_count = bc_inc;
                        n.last_response = rx;
                        n.step = sdspi_pkg::ST_IDLE;
                        r.done_res = 1'b1;
                        r.status = sdspi_pkg::STAT_R1_ERROR;
                        r.r1_value = rx;
                      end else if (cur_i.step == sdspi_pkg::ST_CMD59OFF) begin
                        n.step = sdspi_pkg::ST_CMD16;
                      end else if (cur_i.step == sdspi_pkg::ST_CMD16) begin
                        n.step = sdspi_pkg::ST_CMD58B;
                      end else if (cur_i.step == sdspi_pkg::ST_RD_CMD) begin
                        n = cur_i;
                        n.byte_count = bc_inc;
                        n.last_response = rx;
                        n.step = sdspi_pkg::ST_RD_TOKEN;
                        n.poll_count = '0;
                      end else begin
                        n = cur_i;
                        n.last_response = rx;
                        n.step = sdspi_pkg::ST_WR_DATA;
                        n.byte_count = '0;
                      end
                    end
                    default: begin
                      n = cur_i;
                      n.byte_count = bc_inc;
                      n.last_response = rx;
                      n.step = sdspi_pkg::ST_IDLE;
                      r.done_res = 1'b1;
                      r.status = sdspi_pkg::STAT_R1_ERROR;
                      r.r1_value = rx;
                    end
                  endcase
                end
              end
            end
            default: begin
              n.response_shift = {cur_i.response_shift[23:0], rx};
              n.byte_count = bc_inc;
              if (bc_inc >= 10'd4) begin
                if (cur_i.step == sdspi_pkg::ST_CMD8) begin
                  if (n.response_shift[7:0] != 8'hAA) begin
                    n.step = sdspi_pkg::ST_IDLE;
                    r.done_res = 1'b1;
                    r.status = sdspi_pkg::STAT_ECHO;
                  end else if (n.response_shift[11:8] != 4'h1) begin
                    n.step = sdspi_pkg::ST_IDLE;
                    r.done_res = 1'b1;
                    r.status = sdspi_pkg::STAT_VOLTAGE;
                  end else begin
                    n.step = sdspi_pkg::ST_CMD58A;
                    n.phase = sdspi_pkg::PH_READY;
                    n.byte_count = '0;
                    n.poll_count = '0;
                  end
                end else if (cur_i.step == sdspi_pkg::ST_CMD58A) begin
                  if ((n.response_shift & cfg_i.ocr_mask) != cfg_i.ocr_mask) begin
                    n.step = sdspi_pkg::ST_IDLE;
                    r.done_res = 1'b1;
                    r.status = sdspi_pkg::STAT_VOLTAGE;
                  end else begin
                    n.step = sdspi_pkg::ST_CMD59ON;
                    n.phase = sdspi_pkg::PH_READY;
                    n.byte_count = '0;
                    n.poll_count = '0;
                  end
                end else begin
                  n.card_capacity = n.response_shift[31:30];
                  n.cs_low = 1'b0;
                  n.fast_clk = 1'b1;
                  n.step = sdspi_pkg::ST_IDLE;
                  r.done_res = 1'b1;
                  r.status = sdspi_pkg::STAT_OK;
                end
              end
            end
          endcase
        end else if (cur_i.step == sdspi_pkg::ST_RD_TOKEN) begin
          if (rx == 8'hFE) begin
            n.step = sdspi_pkg::ST_RD_DATA;
            n.byte_count = '0;
          end else begin
            n.poll_count = poll_inc;
            if (poll_over) begin
              n.cs_low = 1'b0;
              n.step = sdspi_pkg::ST_IDLE;
              r.done_res = 1'b1;
              r.status = sdspi_pkg::STAT_NO_TOKEN;
            end
          end
        end else if (cur_i.step == sdspi_pkg::ST_RD_DATA) begin
          r.read_valid = 1'b1;
          r.read_byte = rx;
          n.byte_count = bc_inc;
          if (bc_inc >= 10'(sdspi_pkg::BlockBytes)) begin
            n.step = sdspi_pkg::ST_RD_CRC;
            n.byte_count = '0;
          end
        end else if (cur_i.step == sdspi_pkg::ST_RD_CRC) begin
          n.byte_count = bc_inc;
          if (bc_inc >= 10'd2) begin
            n.cs_low = 1'b0;
            n.step = sdspi_pkg::ST_IDLE;
            r.done_res = 1'b1;
            r.status = sdspi_pkg::STAT_OK;
          end
        end else if (cur_i.step == sdspi_pkg::ST_WR_DATA) begin
          n.byte_count = bc_inc;
          if (bc_inc > 10'(sdspi_pkg::BlockBytes)) begin
            n.step = sdspi_pkg::ST_WR_CRC;
            n.byte_count = '0;
          end
        end else if (cur_i.step == sdspi_pkg::ST_WR_CRC) begin
          n.byte_count = bc_inc;
          if (bc_inc >= 10'd3) begin
            n.last_response = rx;
            n.step = sdspi_pkg::ST_WR_BUSY;
            n.poll_count = '0;
          end
        end else if (cur_i.step == sdspi_pkg::ST_WR_BUSY) begin
          if (rx == 8'hFF) begin
            n.cs_low = 1'b0;
            n.step = sdspi_pkg::ST_IDLE;
            r.done_res = 1'b1;
            if (wcode == 3'd2) begin
              r.status = sdspi_pkg::STAT_ACCEPTED;
            end else if (wcode == 3'd5) begin
              r.status = sdspi_pkg::STAT_CRC_REJECT;
            end else if (wcode == 3'd6) begin
              r.status = sdspi_pkg::STAT_WR_REJECT;
            end else begin
              r.status = sdspi_pkg::STAT_WR_ERROR;
            end
          end else begin
            n.poll_count = poll_inc;
            if (poll_over) begin
              n.step = sdspi_pkg::ST_IDLE;
              r.done_res = 1'b1;
              r.status = sdspi_pkg::STAT_NOT_READY;
            end
          end
        end
      end
    endcase

    cidx = 8'd0;
    ccrc = 8'h95;
    carg = 32'd0;
    case (n.step)
      sdspi_pkg::ST_CMD8: begin
        cidx = 8'd8; carg = 32'h000001AA; ccrc = 8'h87;
      end
      sdspi_pkg::ST_CMD1: begin
        cidx = 8'd1; ccrc = 8'hF9;
      end
      sdspi_pkg::ST_CMD58A, sdspi_pkg::ST_CMD58B: begin
        cidx = 8'd58; ccrc = 8'hFD;
      end
      sdspi_pkg::ST_CMD59ON: begin
        cidx = 8'd59; carg = 32'd1; ccrc = 8'h83;
      end
      sdspi_pkg::ST_CMD55: begin
        cidx = 8'd55; ccrc = 8'h65;
      end
      sdspi_pkg::ST_ACMD41: begin
        cidx = 8'd41; carg = 32'h40000000; ccrc = 8'h77;
      end
      sdspi_pkg::ST_CMD59OFF: begin
        cidx = 8'd59; ccrc = 8'h91;
      end
      sdspi_pkg::ST_CMD16: begin
        cidx = 8'd16; carg = 32'h00000200; ccrc = 8'h15;
      end
      sdspi_pkg::ST_RD_CMD: begin
        cidx = 8'd17; carg = n.latched_address; ccrc = 8'hFF;
      end
      sdspi_pkg::ST_WR_CMD: begin
        cidx = 8'd24; carg = n.latched_address; ccrc = 8'hFF;
      end
      default: begin
        cidx = 8'd0;
      end
    endcase

    r.tx_valid = (n.step != sdspi_pkg::ST_IDLE);
    if (r.tx_valid) begin
      if (n.step inside {[sdspi_pkg::ST_CMD0:sdspi_pkg::ST_WR_CMD]} &&
          n.phase == sdspi_pkg::PH_CMD) begin
        case (n.byte_count)
          10'd0:   r.tx_byte = 8'h40 | cidx;
          10'd1:   r.tx_byte = carg[31:24];
          10'd2:   r.tx_byte = carg[23:16];
          10'd3:   r.tx_byte = carg[15:8];
          10'd4:   r.tx_byte = carg[7:0];
          default: r.tx_byte = ccrc;
        endcase
      end else if (n.step == sdspi_pkg::ST_WR_DATA) begin
        r.tx_byte = (n.byte_count == 10'd0) ? 8'hFE : req_i.write_byte;
        r.need_write_byte = n.byte_count < 10'(sdspi_pkg::BlockBytes);
      end else begin
        r.tx_byte = 8'hFF;
      end
    end
    r.chip_select_low = n.cs_low;
    r.fast_clock = n.fast_clk;

    nxt_o = n;
    res_o = r;
  end

endmodule
